@@ rtl/core/sws_pkg.sv @@
// sws_pkg: field widths, fixed-point constants and the arctangent table
// shared by the swerve wheel steering pipeline; no dependencies
package sws_pkg;

  localparam int VEL_W        = 16;
  localparam int ANGLE_W      = 8;
  localparam int PULSE_W      = 12;
  localparam int BIAS_W       = 11;
  localparam int GAIN_W       = 16;
  localparam int GAIN_FRAC    = 12;
  localparam int GUARD        = 8;
  localparam int Z_W          = 34;
  localparam int ATAN_ENTRIES = 24;
  localparam int SPLIT_W      = 18;
  localparam int G200_W       = 24;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;

  // thresholds 0.05 and 0.1 as reciprocals
  localparam int TURN_MIN_DEN   = 20;
  localparam int MOTION_MIN_DEN = 10;

  // degrees = trunc(|z| * 4068 / (71 << 30)), 923 ~ 2^16 / 71
  localparam int DEG_NUM      = 4068;
  localparam int DEG_DEN      = 71;
  localparam int DEG_RECIP    = 923;
  localparam int DEG_RECIP_SH = 16;

  localparam int ANGLE_MID    = 90;
  localparam int ANGLE_HALF   = 180;
  localparam int PULSE_CENTER = 1500;
  localparam int PULSE_SPAN   = 200;
  localparam int GAIN_RESET   = 4096;

  localparam logic [Z_W-1:0] PI_Q30       = 34'd3373259426;
  localparam logic [29:0]    INV_GAIN_Q30 = 30'd652032874;

  localparam logic [Z_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
    34'd843314857, 34'd497837829, 34'd263043837, 34'd133525159,
    34'd67021687,  34'd33543516,  34'd16775851,  34'd8388437,
    34'd4194283,   34'd2097149,   34'd1048576,   34'd524288,
    34'd262144,    34'd131072,    34'd65536,     34'd32768,
    34'd16384,     34'd8192,      34'd4096,      34'd2048,
    34'd1024,      34'd512,       34'd256,       34'd128
  };

  typedef enum logic [1:0] {
    REG_POS_X = 2'd0,
    REG_POS_Y = 2'd1,
    REG_BIAS  = 2'd2,
    REG_GAIN  = 2'd3
  } reg_idx_t;

endpackage

@@ rtl/core/sws_ifs.sv @@
// sws_in_if and sws_out_if: valid/ready channels for velocity commands
// and wheel results; depends on sws_pkg
interface sws_in_if import sws_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] turn_rate;

  modport source (output valid, output vel_x, output vel_y, output turn_rate,
                  input ready);
  modport sink   (input valid, input vel_x, input vel_y, input turn_rate,
                  output ready);
endinterface

interface sws_out_if import sws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] servo_angle;
  logic [PULSE_W-1:0] drive_pulse;
  logic               reversed;

  modport source (output valid, output servo_angle, output drive_pulse,
                  output reversed, input ready);
  modport sink   (input valid, input servo_angle, input drive_pulse,
                  input reversed, output ready);
endinterface

@@ rtl/core/sws_front.sv @@
// sws_front: turn-rate correction and cordic pre-rotation, two stages
// depends on sws_pkg
module sws_front import sws_pkg::*; #(
  parameter int FRAC_BITS = 12,
  parameter int VW        = 22,
  parameter int CW        = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_in,
  output logic                    ready_out,
  input  logic signed [VEL_W-1:0] vel_x,
  input  logic signed [VEL_W-1:0] vel_y,
  input  logic signed [VEL_W-1:0] turn_rate,
  input  logic signed [VEL_W-1:0] pos_x,
  input  logic signed [VEL_W-1:0] pos_y,
  output logic                    valid_out,
  input  logic                    ready_in,
  output logic signed [CW-1:0]    x_out,
  output logic signed [CW-1:0]    y_out,
  output logic signed [Z_W-1:0]   z_out,
  output logic                    hd_out
);

  localparam logic [20:0]   ONE_T = 21'(1) << FRAC_BITS;
  localparam logic [VW+4:0] ONE_Q = (VW+5)'(1) << FRAC_BITS;

  logic                 t_v_r, q_v_r;
  logic signed [VW-1:0] t_vx_r, t_vy_r, t_vx_nxt, t_vy_nxt;
  logic signed [CW-1:0] q_x_r, q_y_r, q_x_nxt, q_y_nxt;
  logic signed [Z_W-1:0] q_z_r, q_z_nxt;
  logic                 q_hd_r, q_hd_nxt;
  logic                 rdy_t, rdy_q;

  logic [VEL_W-1:0]     aw;
  logic [20:0]          aw20;
  logic                 turn_on;
  logic signed [31:0]   prod_x, prod_y;
  logic signed [32:0]   neg_y, dvx, dvy;

  logic signed [VW:0]   vsum;
  logic [VW:0]          asum;
  logic [VW+4:0]        asum10;
  logic signed [CW-1:0] x0, y0;

  assign rdy_q     = !q_v_r || ready_in;
  assign rdy_t     = !t_v_r || rdy_q;
  assign ready_out = rdy_t;

  // turn stage
  always_comb begin
    aw      = turn_rate[VEL_W-1] ? (~turn_rate + VEL_W'(1)) : turn_rate;
    aw20    = 21'(aw) * 21'(TURN_MIN_DEN);
    turn_on = aw20 > ONE_T;
    prod_x  = 32'(turn_rate) * 32'(pos_x);
    prod_y  = 32'(turn_rate) * 32'(pos_y);
    neg_y   = 33'sd0 - $signed({prod_y[31], prod_y});
    dvx     = neg_y >>> FRAC_BITS;
    dvy     = $signed({prod_x[31], prod_x}) >>> FRAC_BITS;
    t_vx_nxt = $signed({{(VW-VEL_W){vel_x[VEL_W-1]}}, vel_x});
    t_vy_nxt = $signed({{(VW-VEL_W){vel_y[VEL_W-1]}}, vel_y});
    if (turn_on) begin
      t_vx_nxt = t_vx_nxt + $signed(dvx[VW-1:0]);
      t_vy_nxt = t_vy_nxt + $signed(dvy[VW-1:0]);
    end
  end

  // heading test and half-plane fold
  always_comb begin
    vsum     = $signed({t_vx_r[VW-1], t_vx_r}) + $signed({t_vy_r[VW-1], t_vy_r});
    asum     = vsum[VW] ? (~vsum + (VW+1)'(1)) : vsum;
    asum10   = (VW+5)'(asum) * (VW+5)'(MOTION_MIN_DEN);
    q_hd_nxt = ((t_vx_r != '0) && (t_vy_r != '0)) || (asum10 > ONE_Q);
    x0 = $signed({{2{t_vx_r[VW-1]}}, t_vx_r, {GUARD{1'b0}}});
    y0 = $signed({{2{t_vy_r[VW-1]}}, t_vy_r, {GUARD{1'b0}}});
    if (t_vx_r[VW-1]) begin
      q_x_nxt = -x0;
      q_y_nxt = -y0;
      q_z_nxt = t_vy_r[VW-1] ? -$signed(PI_Q30) : $signed(PI_Q30);
    end else begin
      q_x_nxt = x0;
      q_y_nxt = y0;
      q_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
      q_v_r <= 1'b0;
    end else begin
      if (rdy_t) t_v_r <= valid_in;
      if (rdy_q) q_v_r <= t_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_t) begin
      t_vx_r <= t_vx_nxt;
      t_vy_r <= t_vy_nxt;
    end
    if (rdy_q) begin
      q_x_r  <= q_x_nxt;
      q_y_r  <= q_y_nxt;
      q_z_r  <= q_z_nxt;
      q_hd_r <= q_hd_nxt;
    end
  end

  assign valid_out = q_v_r;
  assign x_out     = q_x_r;
  assign y_out     = q_y_r;
  assign z_out     = q_z_r;
  assign hd_out    = q_hd_r;

endmodule

@@ rtl/core/sws_cell.sv @@
// sws_cell: one vectoring cordic micro-rotation with its pipeline register
// depends on sws_pkg for the arctangent table
module sws_cell import sws_pkg::*; #(
  parameter int CW    = 32,
  parameter int STAGE = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_in,
  output logic                  ready_out,
  input  logic signed [CW-1:0]  x_in,
  input  logic signed [CW-1:0]  y_in,
  input  logic signed [Z_W-1:0] z_in,
  input  logic                  hd_in,
  output logic                  valid_out,
  input  logic                  ready_in,
  output logic signed [CW-1:0]  x_out,
  output logic signed [CW-1:0]  y_out,
  output logic signed [Z_W-1:0] z_out,
  output logic                  hd_out
);

  localparam logic signed [Z_W-1:0] ATAN = $signed(ATAN_TAB[STAGE]);

  logic                  v_r;
  logic signed [CW-1:0]  x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [Z_W-1:0] z_r, z_nxt;
  logic                  hd_r;

  assign ready_out = !v_r || ready_in;

  always_comb begin
    xs = x_in >>> STAGE;
    ys = y_in >>> STAGE;
    if (!y_in[CW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_out) begin
      v_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      hd_r <= hd_in;
    end
  end

  assign valid_out = v_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;
  assign hd_out    = hd_r;

endmodule

@@ rtl/core/sws_back.sv @@
// sws_back: magnitude scaling, degree conversion, heading fold and pulse
// saturation in four stages, the last one is the output register; uses sws_pkg
module sws_back import sws_pkg::*; #(
  parameter int FRAC_BITS = 12,
  parameter int CW        = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_in,
  output logic                     ready_out,
  input  logic signed [CW-1:0]     x_in,
  input  logic signed [Z_W-1:0]    z_in,
  input  logic                     hd_in,
  input  logic signed [BIAS_W-1:0] bias,
  input  logic [G200_W-1:0]        g200,
  output logic                     valid_out,
  input  logic                     ready_in,
  output logic [ANGLE_W-1:0]       servo_angle,
  output logic [PULSE_W-1:0]       drive_pulse,
  output logic                     reversed
);

  localparam int XW = CW - 1;          // x is never negative after the pre-fold
  localparam int XH = XW - SPLIT_W;
  localparam int PW = G200_W + XW;
  localparam int SW = PW + 2;
  localparam int SH = GAIN_FRAC + FRAC_BITS + GUARD;
  localparam logic [XW+3:0] STOP_LIM = (XW+4)'(1) << (FRAC_BITS + GUARD);

  logic r1, r2, r3, r4;

  // stage 1
  logic                 s1_v_r, s1_sz_r, s1_hd_r;
  logic [15:0]          s1_t_r, s1_t_nxt;
  logic [47:0]          s1_pl_r, s1_pl_nxt;
  logic [XH+29:0]       s1_ph_r, s1_ph_nxt;
  logic [Z_W-1:0]       az;
  logic [45:0]          pz;
  logic [XW-1:0]        xu;

  // stage 2
  logic                 s2_v_r, s2_sz_r, s2_hd_r;
  logic [XW-1:0]        s2_mag_r, s2_mag_nxt;
  logic [9:0]           s2_qe_r, s2_qe_nxt;
  logic [15:0]          s2_t_r;
  logic [XW+29:0]       msum;
  logic [25:0]          tq;

  // stage 3
  logic                 s3_v_r, s3_rev_r, s3_stop_r, s3_rev_nxt, s3_stop_nxt;
  logic [ANGLE_W-1:0]   s3_angle_r, s3_angle_nxt;
  logic [G200_W+SPLIT_W-1:0] s3_pplo_r, s3_pplo_nxt;
  logic [G200_W+XH-1:0] s3_pphi_r, s3_pphi_nxt;
  logic [15:0]          rem;
  logic [9:0]           q;
  logic signed [10:0]   deg, ang;
  logic [XW+3:0]        mag10;

  // stage 4
  logic                 o_v_r, o_rev_r;
  logic [ANGLE_W-1:0]   o_angle_r;
  logic [PULSE_W-1:0]   o_pulse_r, o_pulse_nxt;
  logic [PW-1:0]        prod;
  logic signed [12:0]   base;
  logic signed [SW-1:0] base_sh, prod_s, psum;

  assign r4        = !o_v_r || ready_in;
  assign r3        = !s3_v_r || r4;
  assign r2        = !s2_v_r || r3;
  assign r1        = !s1_v_r || r2;
  assign ready_out = r1;

  always_comb begin
    az        = z_in[Z_W-1] ? (~z_in + Z_W'(1)) : z_in;
    pz        = 46'(az) * 46'(DEG_NUM);
    s1_t_nxt  = pz[45:30];
    xu        = x_in[XW-1:0];
    s1_pl_nxt = 48'(xu[SPLIT_W-1:0]) * 48'(INV_GAIN_Q30);
    s1_ph_nxt = (XH+30)'(xu[XW-1:SPLIT_W]) * (XH+30)'(INV_GAIN_Q30);
  end

  always_comb begin
    msum       = {s1_ph_r, {SPLIT_W{1'b0}}} + (XW+30)'(s1_pl_r);
    s2_mag_nxt = msum[XW+29:30];
    tq         = 26'(s1_t_r) * 26'(DEG_RECIP);
    s2_qe_nxt  = tq[25:DEG_RECIP_SH];
  end

  // reciprocal estimate is at most one low, one correction step
  always_comb begin
    rem = s2_t_r - 16'(s2_qe_r) * 16'(DEG_DEN);
    q   = s2_qe_r + 10'(rem >= 16'(DEG_DEN));
    if (!s2_hd_r) begin
      deg = '0;
    end else if (s2_sz_r) begin
      deg = -$signed({1'b0, q});
    end else begin
      deg = $signed({1'b0, q});
    end
    if (deg >= -11'sd90 && deg <= 11'sd90) begin
      ang        = 11'(ANGLE_MID) - deg;
      s3_rev_nxt = 1'b0;
    end else if (deg > 11'sd90) begin
      ang        = 11'(ANGLE_MID + ANGLE_HALF) - deg;
      s3_rev_nxt = 1'b1;
    end else begin
      ang        = -deg - 11'(ANGLE_MID);
      s3_rev_nxt = 1'b1;
    end
    s3_angle_nxt = ang[ANGLE_W-1:0];
    mag10        = (XW+4)'(s2_mag_r) * (XW+4)'(MOTION_MIN_DEN);
    s3_stop_nxt  = mag10 < STOP_LIM;
    s3_pplo_nxt  = (G200_W+SPLIT_W)'(g200) * (G200_W+SPLIT_W)'(s2_mag_r[SPLIT_W-1:0]);
    s3_pphi_nxt  = (G200_W+XH)'(g200) * (G200_W+XH)'(s2_mag_r[XW-1:SPLIT_W]);
  end

  always_comb begin
    prod    = {s3_pphi_r, {SPLIT_W{1'b0}}} + PW'(s3_pplo_r);
    base    = 13'(PULSE_CENTER) + $signed({{2{bias[BIAS_W-1]}}, bias});
    base_sh = $signed({{(SW-13){base[12]}}, base}) <<< SH;
    prod_s  = $signed({2'b00, prod});
    psum    = s3_rev_r ? (base_sh - prod_s) : (base_sh + prod_s);
    if (s3_stop_r || psum[SW-1]) begin
      o_pulse_nxt = '0;
    end else if (|psum[SW-2:SH+PULSE_W]) begin
      o_pulse_nxt = '1;
    end else begin
      o_pulse_nxt = psum[SH+PULSE_W-1:SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (r1) s1_v_r <= valid_in;
      if (r2) s2_v_r <= s1_v_r;
      if (r3) s3_v_r <= s2_v_r;
      if (r4) o_v_r  <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_t_r  <= s1_t_nxt;
      s1_pl_r <= s1_pl_nxt;
      s1_ph_r <= s1_ph_nxt;
      s1_sz_r <= z_in[Z_W-1];
      s1_hd_r <= hd_in;
    end
    if (r2) begin
      s2_mag_r <= s2_mag_nxt;
      s2_qe_r  <= s2_qe_nxt;
      s2_t_r   <= s1_t_r;
      s2_sz_r  <= s1_sz_r;
      s2_hd_r  <= s1_hd_r;
    end
    if (r3) begin
      s3_angle_r <= s3_angle_nxt;
      s3_rev_r   <= s3_rev_nxt;
      s3_stop_r  <= s3_stop_nxt;
      s3_pplo_r  <= s3_pplo_nxt;
      s3_pphi_r  <= s3_pphi_nxt;
    end
    if (r4) begin
      o_angle_r <= s3_angle_r;
      o_pulse_r <= o_pulse_nxt;
      o_rev_r   <= s3_rev_r;
    end
  end

  assign valid_out   = o_v_r;
  assign servo_angle = o_angle_r;
  assign drive_pulse = o_pulse_r;
  assign reversed    = o_rev_r;

endmodule

@@ rtl/core/swerve_wheel_steer_and_speed.sv @@
// swerve_wheel_steer_and_speed: top level, register file and the chain
// front -> cordic cells -> back; depends on sws_pkg, sws_ifs, sws_front,
// sws_cell, sws_back
//
//   channel   kind            payload
//   in_if     valid/ready in  vel_x, vel_y, turn_rate (signed q format)
//   out_if    valid/ready out servo_angle, drive_pulse, reversed
//   apb       psel/penable    wheel_pos_x, wheel_pos_y, speed_bias, speed_gain
//
// one transaction per cycle in and out while out_if is not stalled, through a
// pipeline of two front stages, one per cordic cell and four back stages
// synchronous active-low reset empties the pipeline and restores the registers
// each stage holds its transaction while the next one stalls; empty stages keep
// filling, and once all are full a stall on out_if drops in_if.ready that cycle
module swerve_wheel_steer_and_speed import sws_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  sws_in_if.sink            in_if,
  sws_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int N_CELLS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int VW      = 34 - FRAC_BITS;
  localparam int CW      = VW + GUARD + 2;

  logic signed [VEL_W-1:0]  pos_x_r, pos_y_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic [GAIN_W-1:0]        gain_r;
  logic [G200_W-1:0]        g200_r;
  logic                     wr_en;
  reg_idx_t                 reg_idx;

  logic                  c_v   [0:N_CELLS];
  logic                  c_rdy [0:N_CELLS];
  logic signed [CW-1:0]  c_x   [0:N_CELLS];
  logic signed [CW-1:0]  c_y   [0:N_CELLS];
  logic signed [Z_W-1:0] c_z   [0:N_CELLS];
  logic                  c_hd  [0:N_CELLS];

  // register file
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      bias_r  <= '0;
      gain_r  <= GAIN_W'(GAIN_RESET);
      g200_r  <= G200_W'(GAIN_RESET * PULSE_SPAN);
    end else if (wr_en) begin
      case (reg_idx)
        REG_POS_X: pos_x_r <= pwdata[VEL_W-1:0];
        REG_POS_Y: pos_y_r <= pwdata[VEL_W-1:0];
        REG_BIAS:  bias_r  <= pwdata[BIAS_W-1:0];
        REG_GAIN: begin
          gain_r <= pwdata[GAIN_W-1:0];
          g200_r <= G200_W'(pwdata[GAIN_W-1:0]) * G200_W'(PULSE_SPAN);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POS_X: prdata = APB_DW'(unsigned'(pos_x_r));
      REG_POS_Y: prdata = APB_DW'(unsigned'(pos_y_r));
      REG_BIAS:  prdata = APB_DW'(unsigned'(bias_r));
      REG_GAIN:  prdata = APB_DW'(gain_r);
      default:   prdata = '0;
    endcase
  end

  sws_front #(
    .FRAC_BITS (FRAC_BITS),
    .VW        (VW),
    .CW        (CW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_if.valid),
    .ready_out (in_if.ready),
    .vel_x     (in_if.vel_x),
    .vel_y     (in_if.vel_y),
    .turn_rate (in_if.turn_rate),
    .pos_x     (pos_x_r),
    .pos_y     (pos_y_r),
    .valid_out (c_v[0]),
    .ready_in  (c_rdy[0]),
    .x_out     (c_x[0]),
    .y_out     (c_y[0]),
    .z_out     (c_z[0]),
    .hd_out    (c_hd[0])
  );

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    sws_cell #(
      .CW    (CW),
      .STAGE (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (c_v[k]),
      .ready_out (c_rdy[k]),
      .x_in      (c_x[k]),
      .y_in      (c_y[k]),
      .z_in      (c_z[k]),
      .hd_in     (c_hd[k]),
      .valid_out (c_v[k+1]),
      .ready_in  (c_rdy[k+1]),
      .x_out     (c_x[k+1]),
      .y_out     (c_y[k+1]),
      .z_out     (c_z[k+1]),
      .hd_out    (c_hd[k+1])
    );
  end

  sws_back #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_in    (c_v[N_CELLS]),
    .ready_out   (c_rdy[N_CELLS]),
    .x_in        (c_x[N_CELLS]),
    .z_in        (c_z[N_CELLS]),
    .hd_in       (c_hd[N_CELLS]),
    .bias        (bias_r),
    .g200        (g200_r),
    .valid_out   (out_if.valid),
    .ready_in    (out_if.ready),
    .servo_angle (out_if.servo_angle),
    .drive_pulse (out_if.drive_pulse),
    .reversed    (out_if.reversed)
  );

endmodule
